// ----- rtl/core/crb_pkg.sv -----
`timescale 1ns / 1ps
// Package for the cubic root bisection unit: types, constants and the microcode ROM.
package crb_pkg;

   localparam int ROUNDS_DEFAULT = 15;
   localparam int STEP_W         = 4;

   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_MID   = 4'd0;
   localparam step_type STEP_FINAL = 4'd14;

   typedef struct packed {
      logic signed [31:0] left_end;
      logic signed [31:0] right_end;
      logic signed [31:0] value_left;
      logic signed [31:0] value_right;
      logic signed [31:0] coef_const;
      logic signed [31:0] coef_linear;
      logic signed [31:0] coef_square;
      logic signed [31:0] coef_cube;
   } req_type;

   typedef struct packed {
      logic signed [31:0] root;
      logic               exact_zero;
      logic               bad_bracket;
   } rsp_type;

   typedef enum logic [1:0] {MUL_NONE, MUL_LO, MUL_HI} mul_op_type;
   typedef enum logic [1:0] {A_X, A_X2, A_X3} a_sel_type;
   typedef enum logic [1:0] {B_X, B_C1, B_C2, B_C3} b_sel_type;
   typedef enum logic [1:0] {WR_NONE, WR_X2, WR_X3, WR_Q} wr_sel_type;
   typedef enum logic [1:0] {OP_NEXT, OP_DECIDE, OP_FINISH} seq_op_type;
   typedef enum logic {ST_IDLE, ST_RUN} seq_state_type;

   typedef struct packed {
      logic       mid;
      mul_op_type mul;
      a_sel_type  a_sel;
      b_sel_type  b_sel;
      wr_sel_type wr;
      logic       add;
      seq_op_type seq;
   } ucode_type;

   typedef struct packed {
      logic       mid;
      mul_op_type mul;
      a_sel_type  a_sel;
      b_sel_type  b_sel;
      wr_sel_type wr;
      logic       add;
      logic       update;
   } ctl_type;

   typedef struct packed {
      logic f_zero;
      logic flip;
   } stat_type;

   typedef struct packed {
      logic zero;
      logic mid;
   } fin_type;

   // one bisection round: midpoint, five products on the shared multiplier, three adds
   function automatic ucode_type crb_ucode(input step_type step);
      ucode_type uc;
      uc = '{mid: 1'b0, mul: MUL_NONE, a_sel: A_X, b_sel: B_X, wr: WR_NONE,
             add: 1'b0, seq: OP_NEXT};
      unique case (step)
         4'd0:  uc.mid = 1'b1;
         4'd1:  begin uc.mul = MUL_LO; end
         4'd2:  begin uc.mul = MUL_HI; end
         4'd3:  begin uc.wr = WR_X2; uc.mul = MUL_LO; uc.b_sel = B_C1; end
         4'd4:  begin uc.mul = MUL_HI; uc.b_sel = B_C1; end
         4'd5:  begin uc.wr = WR_Q; uc.mul = MUL_LO; uc.a_sel = A_X2; end
         4'd6:  begin uc.mul = MUL_HI; uc.a_sel = A_X2; uc.add = 1'b1; end
         4'd7:  begin
            uc.wr = WR_X3; uc.mul = MUL_LO; uc.a_sel = A_X2; uc.b_sel = B_C2;
         end
         4'd8:  begin uc.mul = MUL_HI; uc.a_sel = A_X2; uc.b_sel = B_C2; end
         4'd9:  begin
            uc.wr = WR_Q; uc.mul = MUL_LO; uc.a_sel = A_X3; uc.b_sel = B_C3;
         end
         4'd10: begin
            uc.mul = MUL_HI; uc.a_sel = A_X3; uc.b_sel = B_C3; uc.add = 1'b1;
         end
         4'd11: uc.wr = WR_Q;
         4'd12: uc.add = 1'b1;
         4'd13: uc.seq = OP_DECIDE;
         4'd14: uc.seq = OP_FINISH;
         default: uc.seq = OP_FINISH;
      endcase
      return uc;
   endfunction

endpackage

// ----- rtl/core/crb_mult.sv -----
`timescale 1ns / 1ps
// Shared two-pass 48x32 fixed-point multiplier with floor shift and 48-bit saturation.
module crb_mult
   import crb_pkg::*;
(
   input  logic               clock,
   input  mul_op_type         op,
   input  logic signed [47:0] a,
   input  logic signed [31:0] b,
   output logic signed [47:0] prod
);

   logic signed [79:0] pp_ff, pp_in;
   logic signed [56:0] pp_lo;
   logic signed [55:0] pp_hi;
   logic signed [63:0] shifted;
   logic               fits;

   assign pp_lo = b * $signed({1'b0, a[23:0]});
   assign pp_hi = b * $signed(a[47:24]);

   always_comb begin
      pp_in = pp_ff;
      case (op)
         MUL_LO:  pp_in = {{23{pp_lo[56]}}, pp_lo};
         MUL_HI:  pp_in = pp_ff + $signed({pp_hi, 24'd0});
         default: pp_in = pp_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      pp_ff <= pp_in;
   end

   assign shifted = pp_ff[79:16];
   assign fits    = (&shifted[63:47]) | ~(|shifted[63:47]);

   always_comb begin
      if (fits)
         prod = shifted[47:0];
      else if (shifted[63])
         prod = {1'b1, 47'd0};
      else
         prod = {1'b0, {47{1'b1}}};
   end

endmodule

// ----- rtl/core/crb_datapath.sv -----
`timescale 1ns / 1ps
// Bracket, coefficient and polynomial registers driven by the microcode control word.
module crb_datapath
   import crb_pkg::*;
(
   input  logic               clock,
   input  logic               load,
   input  req_type            req,
   input  ctl_type            ctl,
   output stat_type           stat,
   output logic signed [31:0] x_value,
   output logic signed [31:0] mid_value
);

   logic signed [31:0] r0_ff, r0_in, r1_ff, r1_in, x_ff, x_in;
   logic signed [31:0] c0_ff, c1_ff, c2_ff, c3_ff;
   logic signed [47:0] x2_ff, x2_in, x3_ff, x3_in, q_ff, q_in, f_ff, f_in;
   logic               v0neg_ff;
   logic signed [32:0] mid_sum;
   logic signed [48:0] acc_sum;
   logic signed [47:0] mul_a, prod;
   logic signed [31:0] mul_b;

   assign mid_sum   = {r0_ff[31], r0_ff} + {r1_ff[31], r1_ff};
   assign mid_value = mid_sum[32:1];
   assign acc_sum   = {f_ff[47], f_ff} + {q_ff[47], q_ff};

   always_comb begin
      case (ctl.a_sel)
         A_X2:    mul_a = x2_ff;
         A_X3:    mul_a = x3_ff;
         default: mul_a = {{16{x_ff[31]}}, x_ff};
      endcase
      case (ctl.b_sel)
         B_C1:    mul_b = c1_ff;
         B_C2:    mul_b = c2_ff;
         B_C3:    mul_b = c3_ff;
         default: mul_b = x_ff;
      endcase
   end

   crb_mult u_mult (
      .clock (clock),
      .op    (ctl.mul),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   always_comb begin
      r0_in = r0_ff;
      r1_in = r1_ff;
      x_in  = x_ff;
      x2_in = x2_ff;
      x3_in = x3_ff;
      q_in  = q_ff;
      f_in  = f_ff;
      if (ctl.mid) begin
         x_in = mid_value;
         f_in = {{16{c0_ff[31]}}, c0_ff};
      end
      case (ctl.wr)
         WR_X2:   x2_in = prod;
         WR_X3:   x3_in = prod;
         WR_Q:    q_in  = prod;
         default: q_in  = q_ff;
      endcase
      if (ctl.add) begin
         if (acc_sum[48] != acc_sum[47])
            f_in = acc_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
         else
            f_in = acc_sum[47:0];
      end
      if (ctl.update) begin
         if (stat.flip)
            r1_in = x_ff;
         else
            r0_in = x_ff;
      end
      if (load) begin
         r0_in = req.left_end;
         r1_in = req.right_end;
      end
   end

   always_ff @(posedge clock) begin
      r0_ff <= r0_in;
      r1_ff <= r1_in;
      x_ff  <= x_in;
      x2_ff <= x2_in;
      x3_ff <= x3_in;
      q_ff  <= q_in;
      f_ff  <= f_in;
      if (load) begin
         v0neg_ff <= req.value_left[31];
         c0_ff    <= req.coef_const;
         c1_ff    <= req.coef_linear;
         c2_ff    <= req.coef_square;
         c3_ff    <= req.coef_cube;
      end
   end

   assign stat.f_zero = (f_ff == 48'sd0);
   assign stat.flip   = f_ff[47] != v0neg_ff;
   assign x_value     = x_ff;

endmodule

// ----- rtl/core/crb_sequencer.sv -----
`timescale 1ns / 1ps
// Microcode sequencer: step counter, round counter, ROM lookup and decide branch.
module crb_sequencer
   import crb_pkg::*;
#(
   parameter int ROUNDS = ROUNDS_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     go,
   input  stat_type stat,
   output ctl_type  ctl,
   output fin_type  fin,
   output logic     running
);

   localparam int RW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

   seq_state_type state_ff, state_in;
   step_type      step_ff, step_in;
   logic [RW-1:0] round_ff, round_in;
   ucode_type     uc;
   logic          last_round;

   assign uc         = crb_ucode(step_ff);
   assign last_round = (round_ff == RW'(ROUNDS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= STEP_MID;
         round_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         round_ff <= round_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      round_in = round_ff;
      fin      = '0;
      ctl      = '{mid: 1'b0, mul: MUL_NONE, a_sel: A_X, b_sel: B_X, wr: WR_NONE,
                   add: 1'b0, update: 1'b0};
      unique case (state_ff)
         ST_IDLE: begin
            if (go) begin
               state_in = ST_RUN;
               step_in  = STEP_MID;
               round_in = '0;
            end
         end
         ST_RUN: begin
            ctl.mid   = uc.mid;
            ctl.mul   = uc.mul;
            ctl.a_sel = uc.a_sel;
            ctl.b_sel = uc.b_sel;
            ctl.wr    = uc.wr;
            ctl.add   = uc.add;
            unique case (uc.seq)
               OP_DECIDE: begin
                  if (stat.f_zero) begin
                     fin.zero = 1'b1;
                     state_in = ST_IDLE;
                  end else begin
                     ctl.update = 1'b1;
                     if (last_round) begin
                        step_in = STEP_FINAL;
                     end else begin
                        round_in = round_ff + 1'b1;
                        step_in  = STEP_MID;
                     end
                  end
               end
               OP_FINISH: begin
                  fin.mid  = 1'b1;
                  state_in = ST_IDLE;
               end
               default: step_in = step_ff + 1'b1;
            endcase
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign running = (state_ff == ST_RUN);

endmodule

// ----- rtl/core/cubic_root_bisection_unit.sv -----
`timescale 1ns / 1ps
// Top level of the cubic root bisection unit.
//
//   channel   ports                      handshake
//   request   start, busy, req_data      taken when start is high and busy is low
//   result    rsp_strobe, rsp_data       valid for the one cycle rsp_strobe is high
//
// A request with a zero end value returns its result in the next cycle.
// Otherwise each bisection round is 14 microcode steps on the one shared
// multiplier (five two-pass products); after the last round a final step
// returns the midpoint, and an exact zero midpoint ends the run early.
// busy is high while the sequencer runs. Synchronous reset clears the
// sequencer and the result strobe. Results cannot be stalled.
module cubic_root_bisection_unit
   import crb_pkg::*;
#(
   parameter int ROUNDS = ROUNDS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   logic     accept, end_left_zero, end_right_zero, go, bad_now;
   logic     rsp_strobe_ff, rsp_strobe_in, bad_ff;
   rsp_type  rsp_ff, rsp_in;
   ctl_type  ctl;
   stat_type stat;
   fin_type  fin;
   logic signed [31:0] x_value, mid_value;

   assign accept         = start && !busy;
   assign end_left_zero  = (req_data.value_left == 32'sd0);
   assign end_right_zero = (req_data.value_right == 32'sd0);
   assign go             = accept && !end_left_zero && !end_right_zero;
   assign bad_now        = !end_left_zero && !end_right_zero &&
                           (req_data.value_left[31] == req_data.value_right[31]);

   crb_sequencer #(.ROUNDS(ROUNDS)) u_seq (
      .clock   (clock),
      .reset   (reset),
      .go      (go),
      .stat    (stat),
      .ctl     (ctl),
      .fin     (fin),
      .running (busy)
   );

   crb_datapath u_dp (
      .clock     (clock),
      .load      (go),
      .req       (req_data),
      .ctl       (ctl),
      .stat      (stat),
      .x_value   (x_value),
      .mid_value (mid_value)
   );

   always_comb begin
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      if (accept && end_left_zero) begin
         rsp_strobe_in = 1'b1;
         rsp_in        = '{root: req_data.left_end, exact_zero: 1'b1, bad_bracket: 1'b0};
      end else if (accept && end_right_zero) begin
         rsp_strobe_in = 1'b1;
         rsp_in        = '{root: req_data.right_end, exact_zero: 1'b1, bad_bracket: 1'b0};
      end else if (fin.zero) begin
         rsp_strobe_in = 1'b1;
         rsp_in        = '{root: x_value, exact_zero: 1'b1, bad_bracket: bad_ff};
      end else if (fin.mid) begin
         rsp_strobe_in = 1'b1;
         rsp_in        = '{root: mid_value, exact_zero: 1'b0, bad_bracket: bad_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_strobe_ff <= 1'b0;
      else
         rsp_strobe_ff <= rsp_strobe_in;
      rsp_ff <= rsp_in;
      if (go)
         bad_ff <= bad_now;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while sequencer still running");

   a_go_busy: assert property (@(posedge clock) disable iff (reset)
      go |=> busy)
      else $error("bisection request did not start the sequencer");

   a_one_finish: assert property (@(posedge clock) disable iff (reset)
      $onehot0({fin.zero, fin.mid, accept && (end_left_zero || end_right_zero)}))
      else $error("two results completed in one cycle");

   a_finish_busy: assert property (@(posedge clock) disable iff (reset)
      (fin.zero || fin.mid) |-> busy)
      else $error("finish outside a running program");

endmodule
